@@ sv/mrtu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU receiver package
// Shared constants, codes, request and result structs, and the CRC-16 step.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CW        = $clog2(BUF_DEPTH + 1);

  localparam logic [CW-1:0] MIN_FRAME = CW'(4);
  localparam logic [CW-1:0] CRC_BYTES = CW'(2);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(BUF_DEPTH);
  localparam logic [15:0]   CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]   CRC_POLY  = 16'hA001;
  localparam logic [7:0]    IDLE_MAX  = 8'hFF;
  localparam logic [7:0]    GAP_RESET = 8'd4;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    KIND_READY = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] len;
    logic       rd_ok;
  } res_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/mrtu_frame_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mrtu_frame_ram (
  input  logic                clk,
  input  mrtu_pkg::mem_req_t  req,
  output logic [7:0]          rdata
);
  import mrtu_pkg::*;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mrtu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame control
// Tracks reception, byte count, idle time and CRC; issues RAM accesses and
// produces the result of each accepted beat.
// ----------------------------------------------------------------------------
module mrtu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          operation,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          read_index,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output mrtu_pkg::mem_req_t  req,
  output mrtu_pkg::res_t      res
);
  import mrtu_pkg::*;

  logic          recv_r, recv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    gap_r;
  logic [CW-1:0] cnt_base;
  logic [15:0]   crc_base;
  logic [7:0]    idle_inc;
  op_t           op;

  assign op = op_t'(operation);

  always_comb begin
    recv_nxt  = recv_r;
    cnt_nxt   = cnt_r;
    idle_nxt  = idle_r;
    crc_nxt   = crc_r;
    req       = '0;
    res       = '0;
    cnt_base  = recv_r ? cnt_r : '0;
    crc_base  = recv_r ? crc_r : CRC_INIT;
    idle_inc  = (idle_r < IDLE_MAX) ? idle_r + 8'd1 : idle_r;
    req.wdata = rx_byte;
    req.waddr = cnt_base[AW-1:0];
    req.raddr = read_index[AW-1:0];
    if (acc) begin
      unique case (op)
        OP_BYTE: begin
          recv_nxt = 1'b1;
          idle_nxt = 8'd0;
          cnt_nxt  = cnt_base;
          crc_nxt  = crc_base;
          if (cnt_base < DEPTH_CNT) begin
            req.we  = 1'b1;
            cnt_nxt = cnt_base + CW'(1);
            crc_nxt = crc_add(crc_base, rx_byte);
          end
        end
        OP_TICK: begin
          idle_nxt = idle_inc;
          if (recv_r && (idle_inc >= gap_r)) begin
            recv_nxt  = 1'b0;
            cnt_nxt   = '0;
            res.valid = (cnt_r >= MIN_FRAME) && (crc_r == 16'h0000);
            res.kind  = KIND_READY;
            res.len   = 8'(cnt_r - CRC_BYTES);
          end
        end
        OP_READ: begin
          req.re    = 1'b1;
          res.valid = 1'b1;
          res.kind  = KIND_READ;
          res.rd_ok = ({1'b0, read_index} < 9'(BUF_DEPTH));
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r <= 1'b0;
      cnt_r  <= '0;
      idle_r <= 8'd0;
      crc_r  <= CRC_INIT;
      gap_r  <= GAP_RESET;
    end else begin
      recv_r <= recv_nxt;
      cnt_r  <= cnt_nxt;
      idle_r <= idle_nxt;
      crc_r  <= crc_nxt;
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
    end
  end

endmodule

@@ sv/modbus_rtu_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver
// Assembles received bytes into frames, checks CRC-16 at the T3.5 gap and
// serves reads of the stored frame bytes.
// ----------------------------------------------------------------------------
// Input beats carry a received byte, a one millisecond tick or a read of a
// stored byte. While the frame holds fewer than 256 bytes, bytes are written
// to the frame RAM and folded into the CRC in the cycle they are accepted. A
// tick that ends a good frame, and every read, produce one output beat: kind
// 0 with the frame length, or kind 1 with the stored byte. The block accepts
// one beat per cycle while in_ready is high. A result passes through the RAM
// stage, where the read is registered, and then the output register.
// The user must write the gap length through cfg_we and cfg_wdata only while
// the block is idle; it does not enforce this. The gap resets to four ticks.
// Reset returns the receiver to idle with a cleared idle counter; the frame RAM
// is not cleared, and only bytes of the current or last frame may be read.
// When the output is stalled, one result waits in the output register and a
// second in the RAM stage; in_ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_read_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mrtu_pkg::*;

  mem_req_t   req;
  res_t       res;
  logic [7:0] ram_rdata;
  logic       acc;
  logic       s1_adv;

  logic       s1_v_r, s1_v_nxt;
  res_t       s1_res_r;
  logic       out_v_r, out_v_nxt;
  logic       out_kind_r;
  logic [7:0] out_len_r;
  logic [7:0] out_data_r;

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign acc      = in_valid && in_ready;

  mrtu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .operation  (in_operation),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .res        (res)
  );

  mrtu_frame_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ready) begin
      s1_v_nxt = acc && res.valid;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_kind_r <= s1_res_r.kind;
      out_len_r  <= (s1_res_r.kind == KIND_READ) ? 8'd0 : s1_res_r.len;
      out_data_r <= ((s1_res_r.kind == KIND_READ) && s1_res_r.rd_ok) ? ram_rdata : 8'd0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_kind         = out_kind_r;
  assign out_frame_length = out_len_r;
  assign out_read_data    = out_data_r;

  a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_READ)) |=> s1_v_r)
    else $error("accepted read did not enter the RAM stage");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both result stages are full");

  a_read_has_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_READ)) |-> (out_frame_length == 8'd0))
    else $error("read result carries a frame length");

  a_ready_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_READY)) |-> (out_read_data == 8'd0))
    else $error("frame ready result carries read data");

endmodule
